/* design/aip_pkg.sv */
`default_nettype none

package aip_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int OFFSET_BITS = 16;
    localparam int BASE_BITS   = 6;
    localparam int CHAR_BITS   = 8;

    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_DEC;

    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic                 first_char;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] parsed_value;
        logic [OFFSET_BITS-1:0]       end_offset;
    } out_word_t;

    // classified character, front to back
    typedef struct packed {
        logic                 first;
        logic [BASE_BITS-1:0] base;
        logic                 is_space;
        logic                 is_sign;
        logic                 is_minus;
        logic                 is_zero;
        logic                 is_x;
        logic                 is_digit;
        logic [BASE_BITS-1:0] digit;
    } cls_word_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

endpackage

`default_nettype wire

/* design/aip_front.sv */
`default_nettype none

module aip_front
    import aip_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [BASE_BITS-1:0] cfg_wr_data,
    input  wire in_word_t             in_word,
    output cls_word_t                 cls_word
);

    logic [BASE_BITS-1:0] base_reg;
    logic [CHAR_BITS-1:0] c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    assign c = in_word.char_code;

    always_comb
    begin
        cls_word          = '0;
        cls_word.first    = in_word.first_char;
        cls_word.base     = base_reg;
        cls_word.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        cls_word.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        cls_word.is_minus = (c == CH_MINUS);
        cls_word.is_zero  = (c == CH_ZERO);
        cls_word.is_x     = (c == CH_LX) || (c == CH_UX);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            cls_word.is_digit = 1'b1;
            cls_word.digit    = BASE_BITS'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            cls_word.is_digit = 1'b1;
            cls_word.digit    = BASE_BITS'(c - CH_LA) + BASE_BITS'(10);
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            cls_word.is_digit = 1'b1;
            cls_word.digit    = BASE_BITS'(c - CH_UA) + BASE_BITS'(10);
        end
    end

endmodule

`default_nettype wire

/* design/aip_queue.sv */
`default_nettype none

module aip_queue
    import aip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cls_word_t push_word,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output cls_word_t      head_word
);

    localparam int DEPTH = 2;

    cls_word_t  mem [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/aip_back.sv */
`default_nettype none

module aip_back
    import aip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_valid,
    input  wire cls_word_t q_word,
    output logic           q_pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word
);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [BASE_BITS-1:0]   base_reg;
    logic [BASE_BITS-1:0]   base_next;
    logic [VALUE_BITS-1:0]  acc_reg;
    logic [VALUE_BITS-1:0]  acc_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [OFFSET_BITS-1:0] cnt_reg;
    logic [OFFSET_BITS-1:0] cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_word_reg;
    out_word_t              out_word_next;

    // start-of-string view of the state
    phase_t                 ph;
    logic [BASE_BITS-1:0]   base_cur;
    logic [VALUE_BITS-1:0]  acc_cur;
    logic [OFFSET_BITS-1:0] cnt_cur;
    logic                   neg_cur;
    logic                   bump;
    logic                   take_digit;
    logic                   emit;
    logic [VALUE_BITS-1:0]  mac;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        ph       = q_word.first ? PH_LEAD : phase_reg;
        base_cur = q_word.first ? q_word.base : base_reg;
        acc_cur  = q_word.first ? '0 : acc_reg;
        cnt_cur  = q_word.first ? '0 : cnt_reg;
        neg_cur  = q_word.first ? 1'b0 : neg_reg;
    end

    // phase walk; one character may fall through several phases
    always_comb
    begin
        phase_next = ph;
        base_next  = base_cur;
        neg_next   = neg_cur;
        bump       = 1'b0;
        take_digit = 1'b0;
        emit       = 1'b0;
        if (ph != PH_IDLE)
        begin
            if (ph == PH_LEAD)
            begin
                if (q_word.is_space)
                begin
                    bump = 1'b1;
                end
                else if (q_word.is_sign)
                begin
                    neg_next   = q_word.is_minus;
                    bump       = 1'b1;
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    phase_next = PH_PREFIX;
                end
            end
            if (phase_next == PH_PREFIX && !bump)
            begin
                if (q_word.is_zero && (base_next == BASE_AUTO || base_next == BASE_HEX))
                begin
                    bump       = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    if (base_next == BASE_AUTO)
                    begin
                        base_next = BASE_DEC;
                    end
                    phase_next = PH_DIGITS;
                end
            end
            if (phase_next == PH_ZERO && !bump)
            begin
                if (q_word.is_x)
                begin
                    bump       = 1'b1;
                    base_next  = BASE_HEX;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    if (base_next == BASE_AUTO)
                    begin
                        base_next = BASE_OCT;
                    end
                    phase_next = PH_DIGITS;
                end
            end
            if (phase_next == PH_DIGITS && !bump)
            begin
                if (q_word.is_digit && q_word.digit < base_next)
                begin
                    take_digit = 1'b1;
                    bump       = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // datapath and output register
    always_comb
    begin
        mac      = acc_cur * VALUE_BITS'(base_next) + VALUE_BITS'(q_word.digit);
        acc_next = take_digit ? mac : acc_cur;
        cnt_next = (bump && cnt_cur != '1) ? cnt_cur + OFFSET_BITS'(1) : cnt_cur;

        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        if (q_pop && emit)
        begin
            out_valid_next             = 1'b1;
            out_word_next.parsed_value = neg_cur ? -acc_cur : acc_cur;
            out_word_next.end_offset   = cnt_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            base_reg      <= BASE_RESET;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                cnt_reg   <= cnt_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

/* design/ascii_integer_parser.sv */
// Streaming ASCII-to-integer converter (strtol style), one character per word.
// Input channel: in_valid/in_ready with in_word = {char_code, first_char}.
//   first_char set starts a new string; characters outside a string are dropped.
// Output channel: out_valid/out_ready with out_word = {parsed_value, end_offset},
//   at most one word per string, issued at the first character that is not a digit of the radix.
// Config: cfg_wr_en/cfg_wr_data write the radix (0 = auto from prefix); the
//   radix is sampled with the first character of each string.
// Throughput: one character per cycle while no result waits for out_ready. The
//   front classifies the character into a two-entry queue; the back walks the
//   parse state with one multiply-add per character. A terminating character
//   reaches out_valid through the queue stage, then the output register.
// Stall: while a result waits in the output register for out_ready, the back
//   holds every character; the queue then fills its two entries and drops in_ready.
// Reset: parse idle, radix 10, queue empty, no result pending.
`default_nettype none

module ascii_integer_parser
    import aip_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [BASE_BITS-1:0] cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_word_t             in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_word_t                 out_word
);

    cls_word_t cls_word;
    cls_word_t head_word;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;

    assign in_ready = !q_full;

    aip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_word     (in_word),
        .cls_word    (cls_word)
    );

    aip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_word (cls_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (head_word)
    );

    aip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_word    (head_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

/* tb/tb_ascii_integer_parser.sv */
`timescale 1ns / 1ps

module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_CHARS = 190;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_RUN = 200;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [BASE_BITS-1:0] cfg_wr_data = BASE_RESET;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_word_t             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_word_t            out_word;

    in_word_t  char_queue[$];
    out_word_t expected_results[$];
    bit        in_fire = 1'b0;
    bit        no_idle = 1'b0;
    bit        string_start = 1'b0;
    int        error_count = 0;
    int        cycle_count = 0;
    int        chars_made = 0;

    // parser shadow state
    logic [BASE_BITS-1:0]   base_setting = BASE_RESET;
    phase_t                 parse_phase = PH_IDLE;
    logic [VALUE_BITS-1:0]  acc = '0;
    logic                   neg = 1'b0;
    logic [BASE_BITS-1:0]   str_base = BASE_DEC;
    logic [OFFSET_BITS-1:0] consumed = '0;

    ascii_integer_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int digit_of(logic [CHAR_BITS-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LZ)
            return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UZ)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    task automatic count_char();
        if (consumed != '1)
            consumed++;
    endtask

    // advance the shadow parser by one character; done marks a finished number
    task automatic parse_char(input in_word_t w, output bit done, output out_word_t res);
        logic [CHAR_BITS-1:0] c;
        int d;
        c = w.char_code;
        done = 1'b0;
        res = '0;
        if (w.first_char)
        begin
            acc = '0;
            neg = 1'b0;
            consumed = '0;
            str_base = base_setting;
            parse_phase = PH_LEAD;
        end
        if (parse_phase == PH_IDLE)
            return;
        if (parse_phase == PH_LEAD)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            begin
                count_char();
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                neg = (c == CH_MINUS);
                count_char();
                parse_phase = PH_PREFIX;
                return;
            end
            parse_phase = PH_PREFIX;
        end
        if (parse_phase == PH_PREFIX)
        begin
            if (c == CH_ZERO && (str_base == BASE_AUTO || str_base == BASE_HEX))
            begin
                count_char();
                parse_phase = PH_ZERO;
                return;
            end
            if (str_base == BASE_AUTO)
                str_base = BASE_DEC;
            parse_phase = PH_DIGITS;
        end
        if (parse_phase == PH_ZERO)
        begin
            if (c == CH_LX || c == CH_UX)
            begin
                count_char();
                str_base = BASE_HEX;
                parse_phase = PH_DIGITS;
                return;
            end
            // the held zero is already a digit worth nothing
            if (str_base == BASE_AUTO)
                str_base = BASE_OCT;
            parse_phase = PH_DIGITS;
        end
        d = digit_of(c);
        if (d >= 0 && d < int'(str_base))
        begin
            acc = acc * VALUE_BITS'(str_base) + VALUE_BITS'(d);
            count_char();
            return;
        end
        res.parsed_value = neg ? -acc : acc;
        res.end_offset = consumed;
        parse_phase = PH_IDLE;
        done = 1'b1;
    endtask

    // driver: new word only after the previous one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (char_queue.size() != 0 && (no_idle || $urandom_range(99) >= 32))
            begin
                in_word <= char_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && (no_idle || $urandom_range(99) >= 32);
    end

    // monitor: predicts on accepted chars, checks accepted results
    always @(posedge clk)
    begin
        out_word_t want;
        bit got;
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n && cfg_wr_en)
            base_setting = cfg_wr_data;
        if (in_fire)
        begin
            parse_char(in_word, got, want);
            if (got)
                expected_results.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: parsed_value %0d end_offset %0d",
                       out_word.parsed_value, out_word.end_offset);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_word.parsed_value !== want.parsed_value)
                begin
                    $error("parsed_value: expected %0d, actual %0d",
                           want.parsed_value, out_word.parsed_value);
                    error_count++;
                end
                if (out_word.end_offset !== want.end_offset)
                begin
                    $error("end_offset: expected %0d, actual %0d",
                           want.end_offset, out_word.end_offset);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_raw(input logic [CHAR_BITS-1:0] c, input logic f);
        in_word_t w;
        w.char_code = c;
        w.first_char = f;
        char_queue.push_back(w);
        chars_made++;
    endtask

    // next char of the current string; the first one carries the start flag
    task automatic add_char(input logic [CHAR_BITS-1:0] c);
        add_raw(c, string_start);
        string_start = 1'b0;
    endtask

    task automatic add_text(input string s);
        string_start = 1'b1;
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(int d);
        if (d < 10)
            return CH_ZERO + CHAR_BITS'(d);
        return ($urandom_range(1) ? CH_LA : CH_UA) + CHAR_BITS'(d - 10);
    endfunction

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            add_raw(CHAR_BITS'($urandom_range(255)), $urandom_range(3) == 0);
    endtask

    // well-formed number: white space, sign, prefix, digits, terminator
    task automatic add_number(input logic [BASE_BITS-1:0] cfg);
        int eff;
        int n;
        string_start = 1'b1;
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                add_char(($urandom_range(4) == 0) ? CH_SPACE
                         : CHAR_BITS'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(3))
            0: add_char(CH_PLUS);
            1: add_char(CH_MINUS);
            default: ;
        endcase
        eff = (cfg == BASE_AUTO) ? 10 : (cfg > 36) ? 36 : int'(cfg);
        if ((cfg == BASE_AUTO || cfg == BASE_HEX) && $urandom_range(2) == 0)
        begin
            add_char(CH_ZERO);
            if ($urandom_range(3) != 0)
            begin
                add_char($urandom_range(1) ? CH_LX : CH_UX);
                eff = 16;
            end
            else if (cfg == BASE_AUTO)
                eff = 8;
        end
        else if ($urandom_range(9) == 0)
            add_char(CH_ZERO);
        // long runs can wrap the accumulator
        n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(4);
        repeat (n)
            add_char(digit_char($urandom_range(eff - 1)));
        case ($urandom_range(5))
            0: add_char('0);
            1: add_char(CH_SPACE);
            2: add_char(CHAR_BITS'($urandom_range(128, 255)));
            3: add_char(CHAR_BITS'($urandom_range(255)));
            4: add_char(";");
            default: add_char((eff < 36) ? digit_char($urandom_range(eff, 35)) : ".");
        endcase
        if ($urandom_range(3) == 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
                add_raw(CHAR_BITS'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (char_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_base(input logic [BASE_BITS-1:0] b);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [BASE_BITS-1:0] phase_bases[$];
        int target;
        phase_bases = '{BASE_HEX, 6'd1, 6'd36, 6'd63, 6'd2, BASE_AUTO, BASE_OCT,
                        BASE_BITS'($urandom_range(3, 35)), BASE_DEC};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset radix: idle input, NUL and high-code ends, restart, no digits
        add_raw(8'hFF, 1'b0);
        add_text("\t+7");
        add_raw(8'h00, 1'b0);
        add_text("-99");
        add_raw(8'hFF, 1'b0);
        add_text("12");
        add_text("5,");
        add_text(" -!");
        add_raw("3", 1'b0);
        wait_idle();

        // auto radix: bare prefix, octal, upper-case hex prefix
        write_base(BASE_AUTO);
        add_text("0x;");
        add_text("017 ");
        add_text("0XfG");
        wait_idle();

        foreach (phase_bases[p])
        begin
            write_base(phase_bases[p]);
            no_idle = (phase_bases[p] == 6'd63);
            if (no_idle)
            begin
                // long white-space run ahead of a short number
                string_start = 1'b1;
                repeat (LONG_RUN) add_char(CH_SPACE);
                add_char(CH_MINUS);
                add_char("5");
                add_char(";");
            end
            target = chars_made + PHASE_CHARS;
            while (chars_made < target)
            begin
                if ($urandom_range(6) == 0)
                    add_noise();
                else
                    add_number(phase_bases[p]);
            end
            wait_idle();
            no_idle = 1'b0;
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
design/aip_pkg.sv
design/aip_front.sv
design/aip_queue.sv
design/aip_back.sv
design/ascii_integer_parser.sv
tb/tb_ascii_integer_parser.sv
